@@ design/arm_mechanism_mode_controller_assert.svh @@
// assertion macros shared by the checker
`ifndef ARM_MECHANISM_MODE_CONTROLLER_ASSERT_SVH
`define ARM_MECHANISM_MODE_CONTROLLER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define AMM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define AMM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/amm_pkg.sv @@
`default_nettype none

package amm_pkg;

    localparam int SINE_ENTRIES_DEF = 360;
    localparam int DEG_COUNT        = 360;

    // arm modes
    localparam logic [2:0] MODE_START   = 3'd0;
    localparam logic [2:0] MODE_STOW    = 3'd1;
    localparam logic [2:0] MODE_OUT     = 3'd2;
    localparam logic [2:0] MODE_COLLECT = 3'd3;
    localparam logic [2:0] MODE_MANUAL  = 3'd4;

    // arm commands
    localparam logic [1:0] CMD_KEEP  = 2'd0;
    localparam logic [1:0] CMD_DRIVE = 2'd1;
    localparam logic [1:0] CMD_BRAKE = 2'd2;

    // intake commands
    localparam logic [1:0] INTAKE_STOP    = 2'd0;
    localparam logic [1:0] INTAKE_FORWARD = 2'd1;
    localparam logic [1:0] INTAKE_REVERSE = 2'd2;

    // register indexes
    localparam logic [2:0] REG_ANGLE_MIN     = 3'd0;
    localparam logic [2:0] REG_ANGLE_MAX     = 3'd1;
    localparam logic [2:0] REG_ANGLE_COLLECT = 3'd2;
    localparam logic [2:0] REG_ANGLE_SCORE   = 3'd3;
    localparam logic [2:0] REG_ANGLE_UP      = 3'd4;
    localparam logic [2:0] REG_GAIN_P        = 3'd5;
    localparam logic [2:0] REG_GAIN_FF       = 3'd6;
    localparam logic [2:0] REG_RING_CURRENT  = 3'd7;

    localparam int CFG_DATA_W = 14;

    // register reset values
    localparam logic [8:0]  RST_ANGLE_MIN     = 9'd17;
    localparam logic [8:0]  RST_ANGLE_MAX     = 9'd265;
    localparam logic [8:0]  RST_ANGLE_COLLECT = 9'd58;
    localparam logic [8:0]  RST_ANGLE_SCORE   = 9'd200;
    localparam logic [8:0]  RST_ANGLE_UP      = 9'd138;
    localparam logic [9:0]  RST_GAIN_P        = 10'd96;
    localparam logic [13:0] RST_GAIN_FF       = 14'd960;
    localparam logic [11:0] RST_RING_CURRENT  = 12'd2000;

    // tick thresholds
    localparam logic [7:0] STEP_MAX        = 8'd255;
    localparam logic [7:0] STEP_REV_LO     = 8'd20;
    localparam logic [7:0] STEP_REV_HI     = 8'd100;
    localparam logic [7:0] STEP_RETURN     = 8'd200;
    localparam logic [5:0] CLAMP_MAX       = 6'd63;
    localparam logic [5:0] CLAMP_LOCKOUT   = 6'd40;
    localparam logic [9:0] COLLECT_MARGIN  = 10'd10;

    localparam logic signed [14:0] VOLT_MANUAL = 15'sd7000;
    localparam logic signed [14:0] VOLT_MAX    = 15'sd12000;
    localparam logic signed [21:0] SUM_MAX     = 22'sd12000;
    localparam logic signed [30:0] FF_ROUND    = 31'sd16384;

    localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

    typedef struct packed {
        logic [8:0]  angle_min;
        logic [8:0]  angle_max;
        logic [8:0]  angle_collect;
        logic [8:0]  angle_score;
        logic [8:0]  angle_up;
        logic [9:0]  gain_p_mv;
        logic [13:0] gain_ff_mv;
        logic [11:0] ring_current_min;
    } cfg_t;

    typedef struct packed {
        logic btn_b;
        logic btn_down;
        logic btn_l1;
        logic btn_l2;
        logic btn_r1;
        logic btn_r2;
        logic btn_up;
        logic btn_y;
        logic btn_right;
    } btn_t;

    // first stage word handed to the drive stages
    typedef struct packed {
        logic [1:0]        cmd;
        logic [1:0]        intake;
        logic              clamp;
        logic              rush;
        logic [2:0]        mode;
        logic              use_pos;
        logic signed [14:0] volts_fixed;
        logic [8:0]        target;
        logic [8:0]        angle;
    } tick_word_t;

    typedef logic signed [15:0] sine_rom_t [0:DEG_COUNT-1];

    // restoring division, elaboration only
    function automatic longint unsigned udiv(input longint unsigned num,
                                             input longint unsigned den);
        longint unsigned rem;
        longint unsigned quo;
        rem = 0;
        quo = 0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = (rem << 1) | ((num >> i) & 64'd1);
            if (rem >= den)
            begin
                rem = rem - den;
                quo = quo | (64'd1 << i);
            end
        end
        return quo;
    endfunction

    // q15 sine of 2*pi*k/entries by a seven-term series
    function automatic logic signed [15:0] sine_q15(input int k, input int entries);
        longint unsigned f;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned r;
        longint unsigned t;
        logic neg;
        f = udiv(longint'(k) << 32, longint'(entries));
        neg = 1'b0;
        if (f >= (64'd1 << 31))
        begin
            neg = 1'b1;
            f = f - (64'd1 << 31);
        end
        if (f > (64'd1 << 30))
            f = (64'd1 << 31) - f;
        x = (f * TWO_PI_Q30) >> 32;
        x2 = (x * x) >> 30;
        term = x;
        sum = x;
        for (int n = 1; n <= 6; n++)
        begin
            t = (term * x2) >> 30;
            case (n)
                1: term = t / 6;
                2: term = t / 20;
                3: term = t / 42;
                4: term = t / 72;
                5: term = t / 110;
                default: term = t / 156;
            endcase
            if ((n % 2) == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        r = (sum + (64'd1 << 14)) >> 15;
        if (r > 64'd32767)
            r = 64'd32767;
        return neg ? -$signed(r[15:0]) : $signed(r[15:0]);
    endfunction

    // table indexed by whole degree of the gravity angle
    function automatic sine_rom_t build_sine_rom(input int entries);
        sine_rom_t rom;
        int idx;
        for (int d = 0; d < DEG_COUNT; d++)
        begin
            idx = (d * entries) / DEG_COUNT;
            if (idx >= entries)
                idx = entries - 1;
            rom[d] = sine_q15(idx, entries);
        end
        return rom;
    endfunction

endpackage

`default_nettype wire

@@ design/amm_tick.sv @@
`default_nettype none

module amm_tick #(
    parameter int SINE_ENTRIES = amm_pkg::SINE_ENTRIES_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  amm_pkg::cfg_t       cfg,
    input  wire                 in_valid,
    output logic                in_stall,
    input  amm_pkg::btn_t       btn,
    input  wire [8:0]           arm_angle,
    input  wire [11:0]          intake_current,
    output logic                s1_valid,
    output amm_pkg::tick_word_t s1_word,
    output logic signed [15:0]  s1_sine,
    input  wire                 take
);

    localparam amm_pkg::sine_rom_t SINE_ROM = amm_pkg::build_sine_rom(SINE_ENTRIES);

    logic [2:0] mode_reg, mode_next;
    logic [7:0] step_reg, step_next;
    logic [5:0] clamp_ticks_reg, clamp_ticks_next;
    logic       clamp_reg, clamp_next;
    logic       rush_reg, rush_next;
    logic       valid_reg;
    amm_pkg::tick_word_t word_reg, word_next;
    logic signed [15:0]  sine_reg;

    logic       load;
    logic       accept;
    logic [7:0] step_inc;
    logic [8:0] target_sel;
    logic [10:0] deg_sum;
    logic [8:0] deg;

    assign load     = !valid_reg || take;
    assign accept   = in_valid && load;
    assign in_stall = !load;

    // gravity angle (angle_up - arm_angle) mod 360
    assign deg_sum = 11'({2'b0, cfg.angle_up}) + 11'd720 - 11'({2'b0, arm_angle});

    always_comb
    begin
        if (deg_sum >= 11'd1080)
            deg = 9'(deg_sum - 11'd1080);
        else if (deg_sum >= 11'd720)
            deg = 9'(deg_sum - 11'd720);
        else if (deg_sum >= 11'd360)
            deg = 9'(deg_sum - 11'd360);
        else
            deg = deg_sum[8:0];
    end

    always_comb
    begin
        step_inc = (step_reg < amm_pkg::STEP_MAX) ? step_reg + 8'd1 : step_reg;

        // intake follows the mode held before the tick
        if (btn.btn_r2 || (mode_reg == amm_pkg::MODE_OUT
                && step_reg > amm_pkg::STEP_REV_LO && step_reg < amm_pkg::STEP_REV_HI))
            word_next.intake = amm_pkg::INTAKE_REVERSE;
        else if (btn.btn_r1 || (mode_reg == amm_pkg::MODE_COLLECT
                && {1'b0, arm_angle} < {1'b0, cfg.angle_collect} + amm_pkg::COLLECT_MARGIN))
            word_next.intake = amm_pkg::INTAKE_FORWARD;
        else
            word_next.intake = amm_pkg::INTAKE_STOP;

        if (btn.btn_up && clamp_ticks_reg > amm_pkg::CLAMP_LOCKOUT)
        begin
            clamp_next       = !clamp_reg;
            clamp_ticks_next = '0;
        end
        else
        begin
            clamp_next       = clamp_reg;
            clamp_ticks_next = (clamp_ticks_reg < amm_pkg::CLAMP_MAX)
                               ? clamp_ticks_reg + 6'd1 : clamp_ticks_reg;
        end

        if (btn.btn_y)
            rush_next = 1'b1;
        else if (btn.btn_right)
            rush_next = 1'b0;
        else
            rush_next = rush_reg;

        mode_next             = mode_reg;
        step_next             = step_inc;
        word_next.cmd         = amm_pkg::CMD_KEEP;
        word_next.use_pos     = 1'b0;
        word_next.volts_fixed = '0;
        target_sel            = cfg.angle_min;

        case (mode_reg)
            amm_pkg::MODE_STOW:
            begin
                word_next.cmd     = amm_pkg::CMD_DRIVE;
                word_next.use_pos = 1'b1;
                target_sel        = cfg.angle_min;
                if (btn.btn_b)
                    mode_next = amm_pkg::MODE_OUT;
                else if (btn.btn_down)
                    mode_next = amm_pkg::MODE_COLLECT;
                else if (btn.btn_l1 || btn.btn_l2)
                    mode_next = amm_pkg::MODE_MANUAL;
            end
            amm_pkg::MODE_OUT:
            begin
                word_next.cmd     = amm_pkg::CMD_DRIVE;
                word_next.use_pos = 1'b1;
                target_sel        = cfg.angle_score;
                if (step_inc > amm_pkg::STEP_RETURN)
                    mode_next = amm_pkg::MODE_STOW;
            end
            amm_pkg::MODE_COLLECT:
            begin
                if (btn.btn_down)
                begin
                    word_next.cmd     = amm_pkg::CMD_DRIVE;
                    word_next.use_pos = 1'b1;
                    target_sel        = cfg.angle_collect;
                end
                else if (btn.btn_l1 || btn.btn_l2)
                    mode_next = amm_pkg::MODE_MANUAL;
                else if (intake_current < cfg.ring_current_min)
                    mode_next = amm_pkg::MODE_STOW;
                else
                begin
                    mode_next = amm_pkg::MODE_OUT;
                    step_next = '0;
                end
            end
            amm_pkg::MODE_MANUAL:
            begin
                if (btn.btn_l1)
                begin
                    word_next.cmd         = amm_pkg::CMD_DRIVE;
                    word_next.volts_fixed = amm_pkg::VOLT_MANUAL;
                end
                else if (btn.btn_l2)
                begin
                    word_next.cmd         = amm_pkg::CMD_DRIVE;
                    word_next.volts_fixed = -amm_pkg::VOLT_MANUAL;
                end
                else
                    word_next.cmd = amm_pkg::CMD_BRAKE;
                if (btn.btn_b)
                    mode_next = amm_pkg::MODE_OUT;
                else if (btn.btn_down)
                    mode_next = amm_pkg::MODE_COLLECT;
            end
            default:
                mode_next = amm_pkg::MODE_STOW;
        endcase

        // upper clamp wins over lower
        if (target_sel > cfg.angle_max)
            word_next.target = cfg.angle_max;
        else if (target_sel < cfg.angle_min)
            word_next.target = cfg.angle_min;
        else
            word_next.target = target_sel;

        word_next.angle = arm_angle;
        word_next.clamp = clamp_next;
        word_next.rush  = rush_next;
        word_next.mode  = mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= amm_pkg::MODE_START;
            step_reg        <= '0;
            clamp_ticks_reg <= '0;
            clamp_reg       <= 1'b0;
            rush_reg        <= 1'b0;
            valid_reg       <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg        <= mode_next;
                step_reg        <= step_next;
                clamp_ticks_reg <= clamp_ticks_next;
                clamp_reg       <= clamp_next;
                rush_reg        <= rush_next;
            end
            if (load)
                valid_reg <= in_valid;
        end
    end

    // word payload and sine table read, registered
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg <= word_next;
            sine_reg <= SINE_ROM[deg];
        end
    end

    assign s1_valid = valid_reg;
    assign s1_word  = word_reg;
    assign s1_sine  = sine_reg;

endmodule

`default_nettype wire

@@ design/amm_drive.sv @@
`default_nettype none

module amm_drive (
    input  wire                 clk,
    input  wire                 rst_n,
    input  amm_pkg::cfg_t       cfg,
    input  wire                 s1_valid,
    input  amm_pkg::tick_word_t s1_word,
    input  wire signed [15:0]   s1_sine,
    output logic                take,
    output logic                out_valid,
    input  wire                 out_stall,
    output logic [1:0]          arm_cmd,
    output logic signed [14:0]  arm_volts,
    output logic [1:0]          intake_cmd,
    output logic                clamp_engaged,
    output logic                rush_deployed,
    output logic [2:0]          arm_mode
);

    logic                v2_reg;
    amm_pkg::tick_word_t w2_reg;
    logic signed [20:0]  p_reg, p_next;
    logic signed [30:0]  ffp_reg, ffp_next;
    logic signed [9:0]   diff;

    logic                out_valid_reg;
    logic [1:0]          cmd_reg;
    logic signed [14:0]  volts_reg, volts_next;
    logic [1:0]          intake_reg;
    logic                clamp_reg;
    logic                rush_reg;
    logic [2:0]          mode_reg;

    logic                ready3;
    logic signed [30:0]  ff_rnd;
    logic signed [15:0]  ff;
    logic signed [21:0]  sum;

    assign ready3 = !out_valid_reg || !out_stall;
    assign take   = !v2_reg || ready3;

    // proportional term and feedforward product
    assign diff     = $signed({1'b0, s1_word.target}) - $signed({1'b0, s1_word.angle});
    assign p_next   = $signed({1'b0, cfg.gain_p_mv}) * diff;
    assign ffp_next = $signed({1'b0, cfg.gain_ff_mv}) * s1_sine;

    // floor((prod + 16384) / 32768)
    assign ff_rnd = ffp_reg + amm_pkg::FF_ROUND;
    assign ff     = ff_rnd[30:15];
    assign sum    = {p_reg[20], p_reg} + {{6{ff[15]}}, ff};

    always_comb
    begin
        if (!w2_reg.use_pos)
            volts_next = w2_reg.volts_fixed;
        else if (sum > amm_pkg::SUM_MAX)
            volts_next = amm_pkg::VOLT_MAX;
        else if (sum < -amm_pkg::SUM_MAX)
            volts_next = -amm_pkg::VOLT_MAX;
        else
            volts_next = sum[14:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
                v2_reg <= s1_valid;
            if (ready3)
                out_valid_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && s1_valid)
        begin
            w2_reg  <= s1_word;
            p_reg   <= p_next;
            ffp_reg <= ffp_next;
        end
        if (ready3 && v2_reg)
        begin
            cmd_reg    <= w2_reg.cmd;
            volts_reg  <= volts_next;
            intake_reg <= w2_reg.intake;
            clamp_reg  <= w2_reg.clamp;
            rush_reg   <= w2_reg.rush;
            mode_reg   <= w2_reg.mode;
        end
    end

    assign out_valid     = out_valid_reg;
    assign arm_cmd       = cmd_reg;
    assign arm_volts     = volts_reg;
    assign intake_cmd    = intake_reg;
    assign clamp_engaged = clamp_reg;
    assign rush_deployed = rush_reg;
    assign arm_mode      = mode_reg;

endmodule

`default_nettype wire

@@ design/arm_mechanism_mode_controller.sv @@
// Arm mechanism mode controller, one input word per control tick.
// Input channel: in_valid / in_stall carry the buttons, arm_angle and
// intake_current of one tick. A word is taken when in_valid is high and
// in_stall is low.
// Output channel: out_valid / out_stall carry arm_cmd, arm_volts, intake_cmd,
// clamp_engaged, rush_deployed and arm_mode, one word per input word, in order.
// Configuration: cfg_we writes cfg_data into register cfg_index at the clock
// edge; change registers only while no tick is in flight.
// From accept to out_valid: the sine table read is registered with the mode
// update at the accepting edge, then the P and feedforward products are
// registered, and then sum and saturation fill the output register.
// Throughput is one word per cycle while out_stall is low.
// Reset clears the mode to start, the tick and clamp counters, the clamp and
// rush states, all valid bits, and loads the register defaults.
// When out_stall is high the output word holds; the two inner stages keep
// filling, so up to two more words are taken before in_stall rises.
`default_nettype none

module arm_mechanism_mode_controller #(
    parameter int SINE_ENTRIES = amm_pkg::SINE_ENTRIES_DEF
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   cfg_we,
    input  wire [2:0]                             cfg_index,
    input  wire [amm_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  wire                                   in_valid,
    output logic                                  in_stall,
    input  wire                                   btn_b,
    input  wire                                   btn_down,
    input  wire                                   btn_l1,
    input  wire                                   btn_l2,
    input  wire                                   btn_r1,
    input  wire                                   btn_r2,
    input  wire                                   btn_up,
    input  wire                                   btn_y,
    input  wire                                   btn_right,
    input  wire [8:0]                             arm_angle,
    input  wire [11:0]                            intake_current,
    output logic                                  out_valid,
    input  wire                                   out_stall,
    output logic [1:0]                            arm_cmd,
    output logic signed [14:0]                    arm_volts,
    output logic [1:0]                            intake_cmd,
    output logic                                  clamp_engaged,
    output logic                                  rush_deployed,
    output logic [2:0]                            arm_mode
);

    amm_pkg::cfg_t       cfg_reg;
    amm_pkg::btn_t       btn;
    logic                s1_valid;
    amm_pkg::tick_word_t s1_word;
    logic signed [15:0]  s1_sine;
    logic                take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.angle_min        <= amm_pkg::RST_ANGLE_MIN;
            cfg_reg.angle_max        <= amm_pkg::RST_ANGLE_MAX;
            cfg_reg.angle_collect    <= amm_pkg::RST_ANGLE_COLLECT;
            cfg_reg.angle_score      <= amm_pkg::RST_ANGLE_SCORE;
            cfg_reg.angle_up         <= amm_pkg::RST_ANGLE_UP;
            cfg_reg.gain_p_mv        <= amm_pkg::RST_GAIN_P;
            cfg_reg.gain_ff_mv       <= amm_pkg::RST_GAIN_FF;
            cfg_reg.ring_current_min <= amm_pkg::RST_RING_CURRENT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                amm_pkg::REG_ANGLE_MIN:     cfg_reg.angle_min        <= cfg_data[8:0];
                amm_pkg::REG_ANGLE_MAX:     cfg_reg.angle_max        <= cfg_data[8:0];
                amm_pkg::REG_ANGLE_COLLECT: cfg_reg.angle_collect    <= cfg_data[8:0];
                amm_pkg::REG_ANGLE_SCORE:   cfg_reg.angle_score      <= cfg_data[8:0];
                amm_pkg::REG_ANGLE_UP:      cfg_reg.angle_up         <= cfg_data[8:0];
                amm_pkg::REG_GAIN_P:        cfg_reg.gain_p_mv        <= cfg_data[9:0];
                amm_pkg::REG_GAIN_FF:       cfg_reg.gain_ff_mv       <= cfg_data[13:0];
                amm_pkg::REG_RING_CURRENT:  cfg_reg.ring_current_min <= cfg_data[11:0];
                default:                    cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    assign btn.btn_b     = btn_b;
    assign btn.btn_down  = btn_down;
    assign btn.btn_l1    = btn_l1;
    assign btn.btn_l2    = btn_l2;
    assign btn.btn_r1    = btn_r1;
    assign btn.btn_r2    = btn_r2;
    assign btn.btn_up    = btn_up;
    assign btn.btn_y     = btn_y;
    assign btn.btn_right = btn_right;

    amm_tick #(
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_tick (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .btn            (btn),
        .arm_angle      (arm_angle),
        .intake_current (intake_current),
        .s1_valid       (s1_valid),
        .s1_word        (s1_word),
        .s1_sine        (s1_sine),
        .take           (take)
    );

    amm_drive u_drive (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .s1_valid      (s1_valid),
        .s1_word       (s1_word),
        .s1_sine       (s1_sine),
        .take          (take),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .arm_cmd       (arm_cmd),
        .arm_volts     (arm_volts),
        .intake_cmd    (intake_cmd),
        .clamp_engaged (clamp_engaged),
        .rush_deployed (rush_deployed),
        .arm_mode      (arm_mode)
    );

endmodule

`default_nettype wire

@@ design/amm_checker.sv @@
`default_nettype none

`include "arm_mechanism_mode_controller_assert.svh"

module amm_checker (
    input wire               clk,
    input wire               rst_n,
    input wire               out_valid,
    input wire               out_stall,
    input wire [1:0]         arm_cmd,
    input wire signed [14:0] arm_volts,
    input wire [2:0]         arm_mode
);

    // no drive means zero volts
    `AMM_ASSERT_NOW(a_idle_volts, out_valid && arm_cmd != amm_pkg::CMD_DRIVE, arm_volts == 15'sd0, "volts without drive")

    // drive stays inside the supply limit
    `AMM_ASSERT_NOW(a_volts_range, out_valid, $signed(arm_volts) <= amm_pkg::VOLT_MAX && $signed(arm_volts) >= -amm_pkg::VOLT_MAX, "volts out of range")

    // every tick leaves start mode behind
    `AMM_ASSERT_NOW(a_no_start, out_valid, arm_mode != amm_pkg::MODE_START, "mode still start after tick")

    // brake only comes from manual mode; the reported mode may already be out or collect
    `AMM_ASSERT_NOW(a_brake_mode, out_valid && arm_cmd == amm_pkg::CMD_BRAKE, arm_mode == amm_pkg::MODE_MANUAL || arm_mode == amm_pkg::MODE_OUT || arm_mode == amm_pkg::MODE_COLLECT, "brake outside manual")

    // a stalled word stays offered
    `AMM_ASSERT_NEXT(a_hold_valid, out_valid && out_stall, out_valid, "stalled word dropped")

endmodule

bind arm_mechanism_mode_controller amm_checker u_amm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .arm_cmd   (arm_cmd),
    .arm_volts (arm_volts),
    .arm_mode  (arm_mode)
);

`default_nettype wire
